>>> rtl/core/vmp_pkg.sv
// Package for the vector-matrix product core.
// Holds field widths, codes, the queue entry type and the saturating adder.
// No dependencies.
package vmp_pkg;

   localparam int VALUE_W         = 32;
   localparam int ACC_W           = 64;
   localparam int COLUMN_W        = 8;
   localparam int POS_W           = 12;
   localparam int REQ_DATA_W      = 32;
   localparam int RSP_DATA_W      = 72;
   localparam int CSR_DATA_W      = 9;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_RESET_COUNT = 256;
   localparam int MAX_ROWS_DEF    = 256;
   localparam int MAX_COLS_DEF    = 256;
   localparam int QUEUE_DEPTH     = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLS_A = 1'b0,
      CSR_COLS_B = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_VECTOR = 1'b0,
      OP_MATRIX = 1'b1
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]           row;
      logic [POS_W-1:0]           col;
      logic                       first;
      logic                       emit;
      logic                       last;
   } vmp_item_type;

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W:0] sum;
      logic signed [ACC_W-1:0] res;
      sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         res = sum[ACC_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> rtl/core/vector_matrix_product_core.sv
// Top level of the vector-matrix product core.
// Depends on vmp_pkg, vmp_front, vmp_queue and vmp_back.
//
// The req channel carries one element per transfer: tuser is 0 for a vector
// element and 1 for a matrix element, tdata holds the signed Q16.16 value.
// First cols_a vector elements are loaded, then the matrix streams in
// row-major order. Each element of the last row yields one rsp transfer:
// tdata holds the saturated Q32.32 column sum and the column index, and
// tlast marks the final column. Loading a vector element or writing a
// register restarts the matrix position.
// Registers are written through csr_wr_en, csr_index and csr_wr_data: index 0
// is cols_a, index 1 is cols_b. The user must write them only while the core
// is idle; the core does not enforce this. It takes one element per cycle while
// the queue has room. A matrix element that yields a result goes through the
// four-entry queue, the memory read and multiply, the accumulate and the output
// register. The accumulator forwards in-flight column sums, so one column per
// cycle is sustained while rsp is not stalled, even with a single matrix column.
// Reset clears the positions, the queue and all valid flags and sets cols_a and
// cols_b to 256, or MAX_ROWS and MAX_COLS if less. While rsp is stalled the back
// end holds, the queue fills, and req_tready drops once four elements wait.
module vector_matrix_product_core #(
   parameter int MAX_ROWS = vmp_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = vmp_pkg::MAX_COLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [vmp_pkg::REQ_DATA_W-1:0]    req_tdata,   // value
   input  logic                              req_tuser,   // operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [vmp_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // result_value, column
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [vmp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [vmp_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import vmp_pkg::*;

   logic         q_ready;
   logic         q_push;
   logic         q_valid;
   logic         q_pop;
   vmp_item_type push_item;
   vmp_item_type head_item;

   vmp_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   vmp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_item (head_item)
   );

   vmp_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_stall_holds_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !q_pop)
      else $error("queue popped while the output is stalled");

   a_push_fills_queue: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> q_valid)
      else $error("accepted element missing from the queue");

endmodule

>>> rtl/core/vmp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module vmp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/vmp_front.sv
// Front end of the vector-matrix product core: configuration registers,
// stream positions and classification of each accepted item.
// Depends on vmp_pkg.
module vmp_front #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [vmp_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 csr_wr_en,
   input  logic [vmp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [vmp_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   input  logic                                 q_ready,
   output logic                                 q_push,
   output vmp_pkg::vmp_item_type                q_item
);
   import vmp_pkg::*;

   localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CA_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RC_W = $clog2(MAX_ROWS + 1);
   localparam int CC_W = $clog2(MAX_COLS + 1);
   localparam int ROWS_RST = (MAX_ROWS < CSR_RESET_COUNT) ? MAX_ROWS : CSR_RESET_COUNT;
   localparam int COLS_RST = (MAX_COLS < CSR_RESET_COUNT) ? MAX_COLS : CSR_RESET_COUNT;

   logic [RC_W-1:0] cols_a_ff, cols_a_in;
   logic [CC_W-1:0] cols_b_ff, cols_b_in;
   logic [RA_W-1:0] vec_pos_ff, vec_pos_in;
   logic [RA_W-1:0] row_pos_ff, row_pos_in;
   logic [CA_W-1:0] col_pos_ff, col_pos_in;
   logic [RC_W-1:0] vec_inc;
   logic [RC_W-1:0] row_inc;
   logic [CC_W-1:0] col_inc;
   logic            vec_wrap;
   logic            row_end;
   logic            col_end;

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   assign vec_inc  = RC_W'(vec_pos_ff) + RC_W'(1);
   assign row_inc  = RC_W'(row_pos_ff) + RC_W'(1);
   assign col_inc  = CC_W'(col_pos_ff) + CC_W'(1);
   assign vec_wrap = (vec_inc >= cols_a_ff);
   assign row_end  = (row_inc >= cols_a_ff);
   assign col_end  = (col_inc >= cols_b_ff);

   always_comb begin
      cols_a_in  = cols_a_ff;
      cols_b_in  = cols_b_ff;
      vec_pos_in = vec_pos_ff;
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;

      q_item.op    = op_type'(req_tuser);
      q_item.value = req_tdata;
      q_item.row   = POS_W'(row_pos_ff);
      q_item.col   = POS_W'(col_pos_ff);
      q_item.first = (row_pos_ff == '0);
      q_item.emit  = row_end;
      q_item.last  = col_end;

      if (op_type'(req_tuser) == OP_VECTOR) begin
         q_item.row = POS_W'(vec_pos_ff);
      end

      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLS_A: begin
               if (csr_wr_data == '0) begin
                  cols_a_in = RC_W'(1);
               end else if (32'(csr_wr_data) > 32'(MAX_ROWS)) begin
                  cols_a_in = RC_W'(MAX_ROWS);
               end else begin
                  cols_a_in = RC_W'(csr_wr_data);
               end
            end
            CSR_COLS_B: begin
               if (csr_wr_data == '0) begin
                  cols_b_in = CC_W'(1);
               end else if (32'(csr_wr_data) > 32'(MAX_COLS)) begin
                  cols_b_in = CC_W'(MAX_COLS);
               end else begin
                  cols_b_in = CC_W'(csr_wr_data);
               end
            end
         endcase
         vec_pos_in = '0;
         row_pos_in = '0;
         col_pos_in = '0;
      end else if (q_push) begin
         if (op_type'(req_tuser) == OP_VECTOR) begin
            vec_pos_in = vec_wrap ? '0 : RA_W'(vec_inc);
            row_pos_in = '0;
            col_pos_in = '0;
         end else begin
            col_pos_in = col_end ? '0 : CA_W'(col_inc);
            if (col_end) begin
               row_pos_in = row_end ? '0 : RA_W'(row_inc);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_a_ff  <= RC_W'(ROWS_RST);
         cols_b_ff  <= CC_W'(COLS_RST);
         vec_pos_ff <= '0;
         row_pos_ff <= '0;
         col_pos_ff <= '0;
      end else begin
         cols_a_ff  <= cols_a_in;
         cols_b_ff  <= cols_b_in;
         vec_pos_ff <= vec_pos_in;
         row_pos_ff <= row_pos_in;
         col_pos_ff <= col_pos_in;
      end
   end

endmodule

>>> rtl/core/vmp_queue.sv
// Short register queue between the front end and the back end.
// Depends on vmp_pkg.
module vmp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  vmp_pkg::vmp_item_type push_item,
   output logic                  ready,
   input  logic                  pop,
   output logic                  valid,
   output vmp_pkg::vmp_item_type head_item
);
   import vmp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   vmp_item_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign ready     = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/vmp_back.sv
// Back end of the vector-matrix product core: vector and column-sum memories,
// multiplier, saturating accumulator with forwarding, and the output register.
// Depends on vmp_pkg and vmp_ram.
module vmp_back #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  vmp_pkg::vmp_item_type           q_item,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [vmp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import vmp_pkg::*;

   localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CA_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic                       adv;
   logic                       is_vector;
   logic                       is_matrix;
   logic [VALUE_W-1:0]         vec_rdata;
   logic [ACC_W-1:0]           sum_rdata;

   logic                       s1_valid_ff;
   logic signed [VALUE_W-1:0]  s1_value_ff;
   logic [CA_W-1:0]            s1_col_ff;
   logic                       s1_first_ff;
   logic                       s1_emit_ff;
   logic                       s1_last_ff;
   logic signed [ACC_W-1:0]    s1_prod;
   logic signed [ACC_W-1:0]    s1_sum;

   logic                       s2_valid_ff;
   logic signed [ACC_W-1:0]    s2_prod_ff;
   logic signed [ACC_W-1:0]    s2_sum_ff;
   logic [CA_W-1:0]            s2_col_ff;
   logic                       s2_first_ff;
   logic                       s2_emit_ff;
   logic                       s2_last_ff;
   logic signed [ACC_W-1:0]    s2_acc;

   logic                       wb_valid_ff;
   logic [CA_W-1:0]            wb_col_ff;
   logic signed [ACC_W-1:0]    wb_acc_ff;

   logic                       out_valid_ff;
   logic [ACC_W-1:0]           out_value_ff;
   logic [COLUMN_W-1:0]        out_column_ff;
   logic                       out_last_ff;

   assign adv       = !out_valid_ff || rsp_tready;
   assign q_pop     = q_valid && adv;
   assign is_vector = q_pop && (q_item.op == OP_VECTOR);
   assign is_matrix = q_pop && (q_item.op == OP_MATRIX);

   vmp_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ROWS)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (is_vector),
      .wr_addr (q_item.row[RA_W-1:0]),
      .wr_data (q_item.value),
      .rd_en   (is_matrix),
      .rd_addr (q_item.row[RA_W-1:0]),
      .rd_data (vec_rdata)
   );

   vmp_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MAX_COLS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (adv && s2_valid_ff),
      .wr_addr (s2_col_ff),
      .wr_data (s2_acc),
      .rd_en   (is_matrix),
      .rd_addr (q_item.col[CA_W-1:0]),
      .rd_data (sum_rdata)
   );

   // Column sums still in flight are forwarded ahead of the memory read data.
   always_comb begin
      s1_prod = $signed(vec_rdata) * s1_value_ff;
      if (s2_valid_ff && (s2_col_ff == s1_col_ff)) begin
         s1_sum = s2_acc;
      end else if (wb_valid_ff && (wb_col_ff == s1_col_ff)) begin
         s1_sum = wb_acc_ff;
      end else begin
         s1_sum = $signed(sum_rdata);
      end
   end

   assign s2_acc = s2_first_ff ? s2_prod_ff : sat_add(s2_sum_ff, s2_prod_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_value_ff   <= q_item.value;
         s1_col_ff     <= q_item.col[CA_W-1:0];
         s1_first_ff   <= q_item.first;
         s1_emit_ff    <= q_item.emit;
         s1_last_ff    <= q_item.last;
         s2_prod_ff    <= s1_prod;
         s2_sum_ff     <= s1_sum;
         s2_col_ff     <= s1_col_ff;
         s2_first_ff   <= s1_first_ff;
         s2_emit_ff    <= s1_emit_ff;
         s2_last_ff    <= s1_last_ff;
         out_value_ff  <= s2_acc;
         out_column_ff <= COLUMN_W'(s2_col_ff);
         out_last_ff   <= s2_last_ff;
         if (s2_valid_ff) begin
            wb_col_ff <= s2_col_ff;
            wb_acc_ff <= s2_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= is_matrix;
         s2_valid_ff  <= s1_valid_ff;
         wb_valid_ff  <= wb_valid_ff || s2_valid_ff;
         out_valid_ff <= s2_valid_ff && s2_emit_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_column_ff, out_value_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
